// File: rtl/wav_pkg.sv
// Package for the RIFF/WAV PCM stream parser: phase and sequencer types,
// result kinds, chunk tags and datapath widths.
// No dependencies.
package wav_pkg;

   // Limits of the sample path.
   localparam int unsigned SAMPLE_BYTES = 2;
   localparam int unsigned MAX_CHANNELS = 8;

   // Divider widths: a 32-bit dividend and a divisor that holds one frame size.
   localparam int unsigned DIV_W  = 32;
   localparam int unsigned DVS_W  = 19;
   localparam int unsigned DCNT_W = 5;

   // Chunk tags and the only accepted fmt body length.
   localparam logic [31:0] TAG_RIFF = 32'h5249_4646;
   localparam logic [31:0] TAG_WAVE = 32'h5741_5645;
   localparam logic [31:0] TAG_FMT  = 32'h666D_7420;
   localparam logic [31:0] TAG_DATA = 32'h6461_7461;
   localparam logic [31:0] FMT_LEN  = 32'h0000_0010;

   // Bits of the seen flags.
   localparam int unsigned SEEN_RIFF = 0;
   localparam int unsigned SEEN_FMT  = 1;
   localparam int unsigned SEEN_DATA = 2;

   // Result kinds.
   localparam logic [2:0] KIND_SAMPLE     = 3'd0;
   localparam logic [2:0] KIND_DONE       = 3'd1;
   localparam logic [2:0] KIND_NOT_RIFF   = 3'd2;
   localparam logic [2:0] KIND_NOT_WAVE   = 3'd3;
   localparam logic [2:0] KIND_BAD_FMTLEN = 3'd4;
   localparam logic [2:0] KIND_COMPRESSED = 3'd5;
   localparam logic [2:0] KIND_BAD_CHAN   = 3'd6;

   // Parsing phase within the file.
   typedef enum logic [2:0] {
      PH_ID,
      PH_LEN,
      PH_WAVE,
      PH_FMT,
      PH_SKIP,
      PH_DATA,
      PH_FINISH,
      PH_HALT
   } phase_type;

   // Sequencer around the shared divider.
   typedef enum logic [2:0] {
      SQ_IDLE,
      SQ_FMT_DIV,
      SQ_FMT_END,
      SQ_DATA_MUL,
      SQ_DATA_DIV,
      SQ_DATA_END
   } seq_type;

endpackage

// File: rtl/wav_pcm_stream_parser.sv
// Top level of the RIFF/WAV PCM stream parser.
// Depends on wav_pkg.
//
// The block takes a WAV file one byte per transfer on the req_ channel:
// req_tdata carries the byte and req_tuser is set on the first byte of a
// new file, which clears all parser state before the byte is taken.
// Results leave on the rsp_ channel: rsp_tuser is the kind (sample, done
// or one of the error codes), rsp_tlast marks the last channel of a frame,
// and rsp_tdata carries the sample, its channel and the sample rate.
// An ordinary byte is taken while the sequencer is idle and the output
// register is free; its result, if any, appears in the output register on
// the next cycle. The shared divider makes one quotient bit per cycle, and
// two bytes wait for it: the last fmt byte of a multichannel file keeps
// req_tready low through the divide (block align divided by channels), and
// the last data length byte through a multiply and a divide (length modulo
// frame size). A mono file's last fmt byte lowers it too; a stall adds.
// After an error or the done result, bytes are taken and ignored until a
// byte with the restart flag arrives.
// Reset clears the parser to expect the RIFF id and empties the output
// register. When the receiver stalls, the result is held and a new byte is
// taken only in the cycle in which the held result is transferred.
module wav_pcm_stream_parser
   import wav_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] data_byte
   input  logic [0:0]  req_tuser,   // [0] restart
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // [15:0] sample_value, [18:16] channel,
                                    // [50:19] pcm_rate, [55:51] zero
   output logic [2:0]  rsp_tuser,   // [2:0] kind
   output logic        rsp_tlast    // frame_end
);

   phase_type         phase_ff, phase_in;
   seq_type           seq_ff, seq_in;
   logic [4:0]        bc_ff, bc_in;
   logic [31:0]       tag_ff, tag_in;
   logic [31:0]       cr_ff, cr_in;
   logic [15:0]       ch_ff, ch_in;
   logic [15:0]       bps_ff, bps_in;
   logic [31:0]       rate_ff, rate_in;
   logic [15:0]       acc_ff, acc_in;
   logic [15:0]       sidx_ff, sidx_in;
   logic [2:0]        cidx_ff, cidx_in;
   logic [2:0]        seen_ff, seen_in;
   logic [DIV_W-1:0]  dq_ff, dq_in;
   logic [DVS_W-1:0]  dr_ff, dr_in;
   logic [DVS_W-1:0]  dd_ff, dd_in;
   logic [DCNT_W-1:0] dcnt_ff, dcnt_in;

   logic              rsp_valid_ff, rsp_valid_in;
   logic [55:0]       rsp_data_ff, rsp_data_in;
   logic [2:0]        rsp_kind_ff, rsp_kind_in;
   logic              rsp_last_ff, rsp_last_in;

   logic              accept;
   logic              out_free;
   logic              out_load;
   logic [2:0]        out_kind;
   logic [15:0]       out_sample;
   logic [2:0]        out_chan;
   logic              out_fend;
   logic [31:0]       out_rate;

   logic              go_fmt_div, go_fmt_end, go_data_mul;
   logic              div_last;

   logic [7:0]        b;
   logic [DVS_W+1:0]  div_diff;
   logic [19:0]       frame_prod;
   logic [15:0]       fmt_bps;
   logic [31:0]       data_len;
   logic [15:0]       drop_n;
   logic [1:0]        pos_v;
   logic [15:0]       acc_v;
   logic [15:0]       nxt_j;
   logic [3:0]        cidx_nx;
   logic              last_chan;

   assign b        = req_tdata;
   assign out_free = !rsp_valid_ff || rsp_tready;
   assign req_tready = (seq_ff == SQ_IDLE) && out_free;
   assign accept   = req_tvalid && req_tready;
   assign div_last = (dcnt_ff == DCNT_W'(DIV_W - 1));

   // Shared divider step: one quotient bit per cycle.
   assign div_diff = {1'b0, dr_ff, dq_ff[DIV_W-1]} - {2'b00, dd_ff};

   // Frame size and the values used when an iteration finishes.
   assign frame_prod = {16'd0, ch_ff[3:0]} * {4'd0, bps_ff};
   assign fmt_bps    = (ch_ff > 16'd1) ? dq_ff[15:0] : bps_ff;
   assign data_len   = cr_ff - {{(32-DVS_W){1'b0}}, dr_ff};

   // Sample assembly helpers for one data byte.
   assign drop_n   = (bps_ff > 16'(SAMPLE_BYTES)) ? bps_ff - 16'(SAMPLE_BYTES) : 16'd0;
   assign pos_v    = 2'(sidx_ff - bps_ff);
   always_comb begin
      acc_v = acc_ff;
      if (sidx_ff >= drop_n) begin
         if (pos_v == 2'd2) begin
            acc_v[7:0] = acc_ff[7:0] | b;
         end else if (pos_v == 2'd3) begin
            acc_v[15:8] = acc_ff[15:8] | b;
         end
      end
   end
   assign nxt_j     = sidx_ff + 16'd1;
   assign cidx_nx   = {1'b0, cidx_ff} + 4'd1;
   assign last_chan = ({12'd0, cidx_nx} >= ch_ff);

   // Sequencer next state.
   always_comb begin
      seq_in = seq_ff;
      case (seq_ff)
         SQ_IDLE: begin
            if (go_fmt_div) begin
               seq_in = SQ_FMT_DIV;
            end else if (go_fmt_end) begin
               seq_in = SQ_FMT_END;
            end else if (go_data_mul) begin
               seq_in = SQ_DATA_MUL;
            end
         end
         SQ_FMT_DIV: begin
            if (div_last) begin
               seq_in = SQ_FMT_END;
            end
         end
         SQ_FMT_END: begin
            if (out_free) begin
               seq_in = SQ_IDLE;
            end
         end
         SQ_DATA_MUL: begin
            seq_in = SQ_DATA_DIV;
         end
         SQ_DATA_DIV: begin
            if (div_last) begin
               seq_in = SQ_DATA_END;
            end
         end
         SQ_DATA_END: begin
            if (out_free) begin
               seq_in = SQ_IDLE;
            end
         end
         default: begin
            seq_in = SQ_IDLE;
         end
      endcase
   end

   // Parser datapath and result generation.
   always_comb begin
      phase_in = phase_ff;
      bc_in    = bc_ff;
      tag_in   = tag_ff;
      cr_in    = cr_ff;
      ch_in    = ch_ff;
      bps_in   = bps_ff;
      rate_in  = rate_ff;
      acc_in   = acc_ff;
      sidx_in  = sidx_ff;
      cidx_in  = cidx_ff;
      seen_in  = seen_ff;
      dq_in    = dq_ff;
      dr_in    = dr_ff;
      dd_in    = dd_ff;
      dcnt_in  = dcnt_ff;
      go_fmt_div  = 1'b0;
      go_fmt_end  = 1'b0;
      go_data_mul = 1'b0;
      out_load   = 1'b0;
      out_kind   = KIND_SAMPLE;
      out_sample = 16'd0;
      out_chan   = 3'd0;
      out_fend   = 1'b0;
      out_rate   = 32'd0;

      case (seq_ff)
         // Divider iterations.
         SQ_FMT_DIV, SQ_DATA_DIV: begin
            dcnt_in = dcnt_ff + DCNT_W'(1);
            if (!div_diff[DVS_W+1]) begin
               dr_in = div_diff[DVS_W-1:0];
               dq_in = {dq_ff[DIV_W-2:0], 1'b1};
            end else begin
               dr_in = {dr_ff[DVS_W-2:0], dq_ff[DIV_W-1]};
               dq_in = {dq_ff[DIV_W-2:0], 1'b0};
            end
         end
         // Load the frame size as divisor and the data length as dividend.
         SQ_DATA_MUL: begin
            dd_in   = (frame_prod[DVS_W-1:0] == '0) ? DVS_W'(1) : frame_prod[DVS_W-1:0];
            dq_in   = cr_ff;
            dr_in   = '0;
            dcnt_in = '0;
         end
         // Finish the fmt chunk with the per-sample byte count.
         SQ_FMT_END: begin
            if (out_free) begin
               bps_in = fmt_bps;
               if (ch_ff == 16'd0 || ch_ff > 16'(MAX_CHANNELS) || fmt_bps == 16'd0) begin
                  out_load = 1'b1;
                  out_kind = KIND_BAD_CHAN;
                  phase_in = PH_HALT;
               end else begin
                  seen_in[SEEN_FMT] = 1'b1;
                  phase_in = PH_ID;
                  bc_in    = '0;
                  cr_in    = '0;
               end
            end
         end
         // Trim the data length to whole frames.
         SQ_DATA_END: begin
            if (out_free) begin
               cr_in = data_len;
               if (data_len == 32'd0) begin
                  out_load = 1'b1;
                  out_kind = KIND_DONE;
                  out_rate = rate_ff;
                  phase_in = PH_HALT;
               end else begin
                  phase_in = PH_DATA;
               end
            end
         end
         default: begin
         end
      endcase

      if (accept) begin
         if (req_tuser[0]) begin
            phase_in = PH_ID;
            bc_in    = '0;
            tag_in   = '0;
            cr_in    = '0;
            ch_in    = 16'd1;
            bps_in   = 16'd1;
            rate_in  = '0;
            acc_in   = '0;
            sidx_in  = '0;
            cidx_in  = '0;
            seen_in  = '0;
         end
         case (phase_in)
            // Chunk id.
            PH_ID: begin
               tag_in = {tag_in[23:0], b};
               bc_in  = bc_in + 5'd1;
               if (bc_in == 5'd4) begin
                  bc_in = '0;
                  if (!seen_in[SEEN_RIFF] && tag_in != TAG_RIFF) begin
                     out_load = 1'b1;
                     out_kind = KIND_NOT_RIFF;
                     phase_in = PH_HALT;
                  end else begin
                     phase_in = PH_LEN;
                     cr_in    = '0;
                  end
               end
            end
            // Little-endian chunk length.
            PH_LEN: begin
               cr_in = {b, cr_ff[31:8]};
               bc_in = bc_ff + 5'd1;
               if (bc_in == 5'd4) begin
                  if (tag_ff == TAG_RIFF && !seen_ff[SEEN_RIFF]) begin
                     phase_in = PH_WAVE;
                     tag_in   = '0;
                     bc_in    = '0;
                  end else if (tag_ff == TAG_FMT && !seen_ff[SEEN_FMT]) begin
                     if (cr_in != FMT_LEN) begin
                        out_load = 1'b1;
                        out_kind = KIND_BAD_FMTLEN;
                        phase_in = PH_HALT;
                     end else begin
                        phase_in = PH_FMT;
                        cr_in    = '0;
                        bc_in    = '0;
                     end
                  end else if (tag_ff == TAG_DATA && !seen_ff[SEEN_DATA]) begin
                     seen_in[SEEN_DATA] = 1'b1;
                     seen_in[SEEN_FMT]  = 1'b1;
                     acc_in      = '0;
                     sidx_in     = '0;
                     cidx_in     = '0;
                     bc_in       = '0;
                     go_data_mul = 1'b1;
                  end else begin
                     phase_in = (cr_in == 32'd0) ? PH_ID : PH_SKIP;
                     bc_in    = '0;
                  end
               end
            end
            // WAVE form type.
            PH_WAVE: begin
               tag_in = {tag_ff[23:0], b};
               bc_in  = bc_ff + 5'd1;
               if (bc_in == 5'd4) begin
                  bc_in = '0;
                  if (tag_in != TAG_WAVE) begin
                     out_load = 1'b1;
                     out_kind = KIND_NOT_WAVE;
                     phase_in = PH_HALT;
                  end else begin
                     seen_in[SEEN_RIFF] = 1'b1;
                     phase_in = PH_ID;
                  end
               end
            end
            // Body of the fmt chunk.
            PH_FMT: begin
               cr_in = {b, cr_ff[31:8]};
               bc_in = bc_ff + 5'd1;
               if (bc_ff == 5'd1 && cr_in[31:16] != 16'd1) begin
                  out_load = 1'b1;
                  out_kind = KIND_COMPRESSED;
                  phase_in = PH_HALT;
               end else begin
                  if (bc_ff == 5'd3) begin
                     ch_in = cr_in[31:16];
                  end
                  if (bc_ff == 5'd7) begin
                     rate_in = cr_in;
                  end
                  if (bc_ff == 5'd13) begin
                     bps_in = cr_in[31:16];
                  end
                  if (bc_ff == 5'd15) begin
                     if (ch_ff > 16'd1) begin
                        go_fmt_div = 1'b1;
                        dd_in   = {{(DVS_W-16){1'b0}}, ch_ff};
                        dq_in   = {{(DIV_W-16){1'b0}}, bps_ff};
                        dr_in   = '0;
                        dcnt_in = '0;
                     end else begin
                        go_fmt_end = 1'b1;
                     end
                  end
               end
            end
            // Skipped chunk body.
            PH_SKIP: begin
               cr_in = cr_ff - 32'd1;
               if (cr_in == 32'd0) begin
                  phase_in = PH_ID;
               end
            end
            // Sample bytes.
            PH_DATA: begin
               if (nxt_j >= bps_ff) begin
                  out_load   = 1'b1;
                  out_kind   = KIND_SAMPLE;
                  out_sample = (bps_ff == 16'd1) ? (acc_v ^ 16'h8000) : acc_v;
                  out_chan   = cidx_ff;
                  out_fend   = last_chan;
                  cidx_in    = last_chan ? 3'd0 : cidx_nx[2:0];
                  acc_in     = '0;
                  sidx_in    = '0;
               end else begin
                  acc_in  = acc_v;
                  sidx_in = nxt_j;
               end
               cr_in = cr_ff - 32'd1;
               if (cr_in == 32'd0) begin
                  phase_in = PH_FINISH;
               end
            end
            // Byte after the last sample byte.
            PH_FINISH: begin
               out_load = 1'b1;
               out_kind = KIND_DONE;
               out_rate = rate_ff;
               phase_in = PH_HALT;
            end
            default: begin
            end
         endcase
      end
   end

   // Output register.
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      rsp_kind_in  = rsp_kind_ff;
      rsp_last_in  = rsp_last_ff;
      if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (out_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {5'd0, out_rate, out_chan, out_sample};
         rsp_kind_in  = out_kind;
         rsp_last_in  = out_fend;
      end
   end

   // Control state.
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_ID;
         seq_ff       <= SQ_IDLE;
         bc_ff        <= '0;
         tag_ff       <= '0;
         cr_ff        <= '0;
         ch_ff        <= 16'd1;
         bps_ff       <= 16'd1;
         rate_ff      <= '0;
         acc_ff       <= '0;
         sidx_ff      <= '0;
         cidx_ff      <= '0;
         seen_ff      <= '0;
         dcnt_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         phase_ff     <= phase_in;
         seq_ff       <= seq_in;
         bc_ff        <= bc_in;
         tag_ff       <= tag_in;
         cr_ff        <= cr_in;
         ch_ff        <= ch_in;
         bps_ff       <= bps_in;
         rate_ff      <= rate_in;
         acc_ff       <= acc_in;
         sidx_ff      <= sidx_in;
         cidx_ff      <= cidx_in;
         seen_ff      <= seen_in;
         dcnt_ff      <= dcnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers.
   always_ff @(posedge clock) begin
      dq_ff       <= dq_in;
      dr_ff       <= dr_in;
      dd_ff       <= dd_in;
      rsp_data_ff <= rsp_data_in;
      rsp_kind_ff <= rsp_kind_in;
      rsp_last_ff <= rsp_last_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;
   assign rsp_tuser  = rsp_kind_ff;
   assign rsp_tlast  = rsp_last_ff;

endmodule

// File: rtl/wav_checker.sv
// Port-level checks for the RIFF/WAV PCM stream parser, bound to its top.
// Depends on wav_pkg and wav_pcm_stream_parser.
module wav_checker
   import wav_pkg::*;
(
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [55:0] rsp_tdata,
   input logic [2:0]  rsp_tuser,
   input logic        rsp_tlast
);

   // No result is offered straight after reset.
   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result offered after reset");

   // A stalled result transfer keeps its contents.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled result changed");

   // Only sample results mark the end of a frame.
   a_last_sample: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != KIND_SAMPLE |-> !rsp_tlast)
      else $error("frame end on a non-sample result");

   // Sample results carry no sample rate, and kinds stay in range.
   a_sample_rate: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == KIND_SAMPLE |-> rsp_tdata[50:19] == 32'd0)
      else $error("sample rate on a sample result");

   a_kind_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser != 3'd7)
      else $error("undefined result kind");

endmodule

bind wav_pcm_stream_parser wav_checker u_wav_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser),
   .rsp_tlast  (rsp_tlast)
);

// File: sim/tb.sv
// Testbench for the RIFF/WAV PCM stream parser: it sends whole and damaged WAV files
// byte by byte and checks every result against a built-in parser model.
// Depends on wav_pkg and on the wav_pcm_stream_parser RTL.
module tb
   import wav_pkg::*;
();
   timeunit 1ns;
   timeprecision 1ps;

   // One predicted or observed result.
   typedef struct {
      logic [2:0]  kind;
      logic [15:0] sample_value;
      logic [2:0]  channel;
      logic        frame_end;
      logic [31:0] pcm_rate;
   } wav_result_type;

   // Parser model and the store of results still to arrive.
   class wav_scoreboard;
      phase_type   ph;
      logic [31:0] cnt, tag, remain, chans, bps, rate, accum, sidx, chidx;
      logic [2:0]  seen;
      wav_result_type pending_results[$];
      int unsigned mismatches, checked, bytes_seen, samples_seen, codes_seen;

      function new();
         clear();
      endfunction

      function void clear();
         ph = PH_ID;
         cnt = 0; tag = 0; remain = 0; rate = 0; accum = 0; sidx = 0; chidx = 0;
         chans = 1; bps = 1; seen = '0;
      endfunction

      function void push(logic [2:0] k, logic [15:0] v, logic [2:0] ch, logic fe,
                         logic [31:0] r);
         wav_result_type e;
         e.kind = k; e.sample_value = v; e.channel = ch; e.frame_end = fe;
         e.pcm_rate = r;
         pending_results.push_back(e);
      endfunction

      // An error stops the parser until the next restart.
      function void flag_error(logic [2:0] k);
         push(k, '0, '0, 1'b0, '0);
         ph = PH_HALT;
      endfunction

      // The fourth length byte decides what to do with the chunk.
      function void end_of_length();
         logic [31:0] frame;
         if (tag == TAG_RIFF && !seen[SEEN_RIFF]) begin
            ph = PH_WAVE;
            tag = 0;
         end else if (tag == TAG_FMT && !seen[SEEN_FMT]) begin
            if (remain != FMT_LEN) begin
               flag_error(KIND_BAD_FMTLEN);
               return;
            end
            ph = PH_FMT;
            remain = 0;
         end else if (tag == TAG_DATA && !seen[SEEN_DATA]) begin
            frame = chans * bps;
            seen[SEEN_DATA] = 1'b1;
            seen[SEEN_FMT] = 1'b1;
            if (frame == 0) frame = 1;
            remain = remain - (remain % frame);
            accum = 0; sidx = 0; chidx = 0;
            if (remain == 0) begin
               push(KIND_DONE, '0, '0, 1'b0, rate);
               ph = PH_HALT;
               return;
            end
            ph = PH_DATA;
         end else begin
            ph = (remain == 0) ? PH_ID : PH_SKIP;
         end
         cnt = 0;
      endfunction

      // Works out the result, if any, of one accepted byte.
      function void note_transfer(logic [7:0] b, logic restart);
         logic [31:0] bw, n, drop, pos, v;
         bw = {24'b0, b};
         bytes_seen++;
         if (restart) clear();
         case (ph)
            PH_ID: begin
               tag = (tag << 8) | bw;
               cnt++;
               if (cnt >= 4) begin
                  cnt = 0;
                  if (!seen[SEEN_RIFF] && tag != TAG_RIFF) flag_error(KIND_NOT_RIFF);
                  else begin
                     ph = PH_LEN;
                     remain = 0;
                  end
               end
            end
            PH_LEN: begin
               remain = (remain >> 8) | (bw << 24);
               cnt++;
               if (cnt >= 4) end_of_length();
            end
            PH_WAVE: begin
               tag = (tag << 8) | bw;
               cnt++;
               if (cnt >= 4) begin
                  cnt = 0;
                  if (tag != TAG_WAVE) flag_error(KIND_NOT_WAVE);
                  else begin
                     seen[SEEN_RIFF] = 1'b1;
                     ph = PH_ID;
                  end
               end
            end
            PH_FMT: begin
               n = cnt;
               remain = (remain >> 8) | (bw << 24);
               cnt++;
               if (n == 1 && (remain >> 16) != 1) flag_error(KIND_COMPRESSED);
               else begin
                  if (n == 3) chans = remain >> 16;
                  if (n == 7) rate = remain;
                  if (n == 13) bps = remain >> 16;
                  if (n == 15) begin
                     if (chans > 1) bps = bps / chans;
                     if (chans == 0 || chans > MAX_CHANNELS || bps == 0)
                        flag_error(KIND_BAD_CHAN);
                     else begin
                        seen[SEEN_FMT] = 1'b1;
                        ph = PH_ID;
                        cnt = 0;
                        remain = 0;
                     end
                  end
               end
            end
            PH_SKIP: begin
               remain--;
               if (remain == 0) ph = PH_ID;
            end
            PH_DATA: begin
               drop = (bps > SAMPLE_BYTES) ? bps - SAMPLE_BYTES : 0;
               if (sidx >= drop) begin
                  pos = (sidx + 4 - bps) & 32'd3;
                  accum = accum | (bw << (8 * pos));
               end
               sidx++;
               if (sidx >= bps) begin
                  v = accum >> 16;
                  if (bps == 1) v = v ^ 32'h8000;
                  push(KIND_SAMPLE, v[15:0], chidx[2:0], chidx + 1 >= chans, '0);
                  chidx = (chidx + 1 >= chans) ? 0 : chidx + 1;
                  accum = 0;
                  sidx = 0;
               end
               remain--;
               if (remain == 0) ph = PH_FINISH;
            end
            PH_FINISH: begin
               push(KIND_DONE, '0, '0, 1'b0, rate);
               ph = PH_HALT;
            end
            default: ;
         endcase
      endfunction

      // Compares one result transfer with the oldest prediction.
      function void check_result(wav_result_type got);
         wav_result_type e;
         checked++;
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected result kind=%0d value=%h", got.kind,
                        got.sample_value);
            return;
         end
         e = pending_results.pop_front();
         if (e.kind == KIND_SAMPLE) samples_seen++;
         else codes_seen++;
         if (got.kind !== e.kind || got.sample_value !== e.sample_value ||
             got.channel !== e.channel || got.frame_end !== e.frame_end ||
             got.pcm_rate !== e.pcm_rate) begin
            mismatches++;
            if (mismatches <= 10) begin
               $display("ERROR: result %0d expected kind=%0d val=%h ch=%0d end=%b rate=%h,",
                        checked, e.kind, e.sample_value, e.channel, e.frame_end,
                        e.pcm_rate);
               $display("       got kind=%0d val=%h ch=%0d end=%b rate=%h",
                        got.kind, got.sample_value, got.channel, got.frame_end,
                        got.pcm_rate);
            end
         end
      endfunction
   endclass

   logic        clock, reset;
   logic        req_tvalid, req_tready;
   logic [7:0]  req_tdata;    // [7:0] data_byte
   logic [0:0]  req_tuser;    // [0] restart
   logic        rsp_tvalid, rsp_tready;
   logic [55:0] rsp_tdata;    // [15:0] sample_value, [18:16] channel, [50:19] pcm_rate
   logic [2:0]  rsp_tuser;    // [2:0] kind
   logic        rsp_tlast;

   wav_scoreboard sb;
   logic [7:0]    file_bytes[$];
   bit            hold_request;
   int unsigned   burst_left, files_sent;

   wav_pcm_stream_parser u_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tuser(req_tuser),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // Watchdog.
   initial begin
      #5ms;
      $display("DONE: errors detected");
      $finish;
   end

   // Transfers on both channels are observed at the rising edge; results first,
   // since a result never belongs to a byte taken in the same cycle.
   always @(posedge clock) begin
      wav_result_type got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got.kind = rsp_tuser;
         got.sample_value = rsp_tdata[15:0];
         got.channel = rsp_tdata[18:16];
         got.frame_end = rsp_tlast;
         got.pcm_rate = rsp_tdata[50:19];
         sb.check_result(got);
      end
      if (!reset && req_tvalid && req_tready) sb.note_transfer(req_tdata, req_tuser[0]);
   end

   // Receiver: a randomly chosen stall pattern, with one long hold-off on request.
   initial begin
      int unsigned mode, tick;
      rsp_tready = 1'b0;
      mode = 0;
      tick = 0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_tready = 1'b0;
            repeat (400) @(negedge clock);
         end
         tick++;
         if (tick % 64 == 0) mode = $urandom_range(0, 3);
         case (mode)
            0: rsp_tready = 1'b1;
            1: rsp_tready = ($urandom_range(0, 3) != 0);
            2: rsp_tready = (tick % 3 == 0);
            default: rsp_tready = $urandom_range(0, 1);
         endcase
      end
   end

   // Offers one byte and holds it until it is taken; bursts end in random gaps.
   task automatic send_byte(logic [7:0] b, logic restart);
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata = b;
      req_tuser = restart;
      do @(posedge clock); while (!req_tready);
      if (--burst_left == 0) begin
         @(negedge clock);
         req_tvalid = 1'b0;
         repeat ($urandom_range(0, 8)) @(negedge clock);
         burst_left = ($urandom_range(0, 7) == 0) ? 200 : $urandom_range(1, 30);
      end
   endtask

   task automatic send_file();
      foreach (file_bytes[i]) send_byte(file_bytes[i], i == 0);
      files_sent++;
   endtask

   function automatic void put_tag(string s);
      for (int i = 0; i < 4; i++) file_bytes.push_back(s[i]);
   endfunction

   function automatic void put_le(logic [31:0] v, int unsigned nbytes);
      for (int i = 0; i < nbytes; i++) file_bytes.push_back(v[8*i +: 8]);
   endfunction

   function automatic void put_random(int unsigned nbytes);
      repeat (nbytes) file_bytes.push_back(8'($urandom_range(0, 255)));
   endfunction

   // Builds one file: RIFF header, optional filler chunks, optional fmt and data.
   function automatic void build_wav(logic [15:0] fmt_code, logic [15:0] chans,
                                     logic [15:0] balign, logic [31:0] rate,
                                     logic [31:0] fmt_len, bit with_fmt, bit fillers,
                                     int unsigned data_len, int unsigned tail);
      int unsigned skip_len;
      file_bytes.delete();
      put_tag("RIFF");
      put_le($urandom, 4);
      put_tag("WAVE");
      if (fillers) begin
         skip_len = $urandom_range(0, 6);
         put_tag("LIST");
         put_le(skip_len, 4);
         put_random(skip_len);
      end
      if (with_fmt) begin
         put_tag("fmt ");
         put_le(fmt_len, 4);
         put_le(fmt_code, 2);
         put_le(chans, 2);
         put_le(rate, 4);
         put_le($urandom, 4);
         put_le(balign, 2);
         put_le($urandom, 2);
      end
      if (fillers) begin
         // Repeated chunks are skipped by their length.
         put_tag("fmt ");
         put_le(32'd3, 4);
         put_random(3);
         put_tag("RIFF");
         put_le(32'd2, 4);
         put_random(2);
      end
      put_tag("data");
      put_le(data_len, 4);
      put_random(data_len + tail);
   endfunction

   initial begin
      int unsigned random_bytes, ch, bsz, pick;
      sb = new();
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      req_tuser = '0;
      hold_request = 1'b0;
      burst_left = 5;
      files_sent = 0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed files: sample widths, dropped bytes, filler chunks and every error.
      build_wav(1, 2, 4, 44100, 16, 1, 1, 12, 2);            send_file();
      build_wav(1, 1, 1, 8000, 16, 1, 0, 6, 1);              send_file();
      build_wav(1, 2, 6, 48000, 16, 1, 0, 13, 0);            send_file();
      build_wav(1, 8, 32, 32'hFFFF_FFFF, 16, 1, 1, 32, 1);   send_file();
      build_wav(1, 8, 48, 0, 16, 1, 0, 48, 0);               send_file();
      build_wav(1, 1, 1, 1, 16, 0, 1, 4, 2);                 send_file();
      build_wav(1, 2, 4, 22050, 16, 1, 0, 3, 3);             send_file();
      build_wav(1, 1, 2, 11025, 16, 1, 0, 0, 2);             send_file();
      build_wav(1, 2, 4, 1000, 18, 1, 0, 0, 0);              send_file();
      build_wav(3, 2, 4, 1000, 16, 1, 0, 0, 0);              send_file();
      build_wav(1, 0, 4, 1000, 16, 1, 0, 0, 0);              send_file();
      build_wav(1, 9, 9, 1000, 16, 1, 0, 0, 0);              send_file();
      build_wav(1, 16'hFFFF, 16'hFFFF, 1000, 16, 1, 0, 0, 0); send_file();
      build_wav(1, 2, 1, 1000, 16, 1, 0, 0, 0);              send_file();
      build_wav(1, 1, 0, 1000, 16, 1, 0, 0, 0);              send_file();
      build_wav(1, 1, 2, 1000, 16, 1, 0, 0, 0);
      file_bytes[3] = "X";                                   send_file();
      build_wav(1, 1, 2, 1000, 16, 1, 0, 0, 0);
      file_bytes[10] = "X";                                  send_file();
      // A file cut short by a restart.
      build_wav(1, 2, 4, 1000, 16, 1, 0, 40, 0);
      file_bytes = file_bytes[0:50];                         send_file();

      // Random files: mostly well formed, some damaged, cut short or pure noise.
      random_bytes = 0;
      while (random_bytes < 150) begin
         if (files_sent == 18) hold_request = 1'b1;
         pick = $urandom_range(0, 19);
         if (pick == 0) begin
            file_bytes.delete();
            put_random($urandom_range(1, 20));
         end else begin
            ch = $urandom_range(1, 8);
            bsz = $urandom_range(1, 4);
            build_wav((pick == 1) ? 16'($urandom_range(0, 3)) : 16'd1,
                      (pick == 2) ? 16'($urandom_range(0, 16)) : 16'(ch),
                      (pick == 3) ? 16'($urandom_range(0, 40)) : 16'(ch * bsz),
                      $urandom, (pick == 4) ? $urandom_range(14, 18) : 16,
                      pick != 5, $urandom_range(0, 1),
                      $urandom_range(0, 40), $urandom_range(0, 3));
            if (pick == 6)
               file_bytes[$urandom_range(0, file_bytes.size() - 1)] = 8'($urandom);
            if (pick == 7) file_bytes = file_bytes[0:$urandom_range(0, file_bytes.size() - 1)];
         end
         random_bytes += file_bytes.size();
         send_file();
      end

      @(negedge clock);
      req_tvalid = 1'b0;
      while (sb.pending_results.size() != 0) @(posedge clock);
      repeat (60) @(posedge clock);

      $display("Sent %0d files (%0d bytes) under bursty input and a stalling receiver.",
               files_sent, sb.bytes_seen);
      $display("Checked %0d results: %0d samples, %0d done or error codes.",
               sb.checked, sb.samples_seen, sb.codes_seen);
      if (sb.mismatches == 0 && sb.pending_results.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// File: sim.f
rtl/wav_pkg.sv
rtl/wav_pcm_stream_parser.sv
rtl/wav_checker.sv
sim/tb.sv
